// ===== hw/rtl/sdc_pkg.sv =====
// Shared types, SLIP codes and the CRC-16/CCITT-FALSE byte update for the SLIP deframer.
// Used by sdc_core and slip_deframer_crc16_check_unit; depends on nothing else.
`default_nettype none

package sdc_pkg;

	localparam logic [7:0] SLIP_END     = 8'hC0;
	localparam logic [7:0] SLIP_ESC     = 8'hDB;
	localparam logic [7:0] SLIP_ESC_END = 8'hDC;
	localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	typedef enum logic [2:0] {
		KIND_DATA     = 3'd0,
		KIND_GOOD     = 3'd1,
		KIND_MISMATCH = 3'd2,
		KIND_RUNT     = 3'd3,
		KIND_OVERFLOW = 3'd4
	} kind_t;

	typedef struct packed {
		logic        valid;
		kind_t       kind;
		logic [7:0]  data_byte;
		logic [7:0]  frame_opcode;
		logic [7:0]  frame_seq;
		logic [7:0]  frame_plen;
		logic [15:0] received_crc;
		logic [15:0] computed_crc;
	} result_t;

	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sdc_core.sv =====
// Frame state of the SLIP deframer: escape flag, byte count, header fields and running CRC.
// Processes one registered byte per step and forms its result; uses sdc_pkg.
`default_nettype none

module sdc_core #(
	parameter int MAX_FRAME   = 256,
	parameter int MAX_PAYLOAD = 250
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire logic [7:0]       rx_byte,
	output sdc_pkg::result_t      result
);

	localparam int CW = $clog2(MAX_FRAME + 1);
	localparam int PW = $clog2(MAX_PAYLOAD + 1);
	localparam int SW = ((CW > PW) ? CW : PW) + 1;

	logic          escape_q;
	logic [CW-1:0] count_q;
	logic [7:0]    opcode_q;
	logic [7:0]    seq_q;
	logic [15:0]   length_q;
	logic [15:0]   crc_q;
	logic [15:0]   crc_field_q;

	logic          escape_d;
	logic [CW-1:0] count_d;
	logic [7:0]    opcode_d;
	logic [7:0]    seq_d;
	logic [15:0]   length_d;
	logic [15:0]   crc_d;
	logic [15:0]   crc_field_d;

	logic [PW-1:0] plen;
	logic [PW+7:0] plen_wide;
	logic [SW-1:0] count_ext;
	logic [SW-1:0] plen_ext;
	logic [7:0]    b;
	logic          take;
	logic          clear;
	logic          whole;
	logic [15:0]   crc_next;

	assign plen      = (length_q > 16'(MAX_PAYLOAD)) ? PW'(MAX_PAYLOAD) : length_q[PW-1:0];
	assign plen_wide = {8'd0, plen};
	assign count_ext = SW'(count_q);
	assign plen_ext  = SW'(plen);
	assign whole     = count_ext >= (plen_ext + SW'(6));
	assign crc_next  = sdc_pkg::crc_update(crc_q, b);

	always_comb begin
		result      = '0;
		take        = 1'b0;
		clear       = 1'b0;
		b           = rx_byte;
		escape_d    = escape_q;
		count_d     = count_q;
		opcode_d    = opcode_q;
		seq_d       = seq_q;
		length_d    = length_q;
		crc_d       = crc_q;
		crc_field_d = crc_field_q;

		if (count_q >= CW'(MAX_FRAME)) begin
			result.valid = 1'b1;
			result.kind  = sdc_pkg::KIND_OVERFLOW;
			clear        = 1'b1;
		end else if (rx_byte == sdc_pkg::SLIP_END) begin
			if (count_q != '0) begin
				result.valid = 1'b1;
				if (count_q < CW'(4)) begin
					result.kind = sdc_pkg::KIND_RUNT;
				end else begin
					result.kind = (whole && crc_field_q == crc_q) ? sdc_pkg::KIND_GOOD
						: sdc_pkg::KIND_MISMATCH;
					result.frame_opcode = opcode_q;
					result.frame_seq    = seq_q;
					result.frame_plen   = plen_wide[7:0];
					result.received_crc = crc_field_q;
					result.computed_crc = crc_q;
				end
			end
			clear = 1'b1;
		end else if (rx_byte == sdc_pkg::SLIP_ESC) begin
			escape_d = 1'b1;
		end else if (escape_q) begin
			escape_d = 1'b0;
			if (rx_byte == sdc_pkg::SLIP_ESC_END) begin
				b    = sdc_pkg::SLIP_END;
				take = 1'b1;
			end else if (rx_byte == sdc_pkg::SLIP_ESC_ESC) begin
				b    = sdc_pkg::SLIP_ESC;
				take = 1'b1;
			end
		end else begin
			take = 1'b1;
		end

		if (take) begin
			result.valid     = 1'b1;
			result.kind      = sdc_pkg::KIND_DATA;
			result.data_byte = b;
			count_d          = count_q + CW'(1);
			if (count_q == CW'(0)) begin
				opcode_d = b;
			end
			if (count_q == CW'(1)) begin
				seq_d = b;
			end
			if (count_q == CW'(2)) begin
				length_d = {length_q[15:8], b};
			end
			if (count_q == CW'(3)) begin
				length_d = {b, length_q[7:0]};
			end
			if (count_q < CW'(4)) begin
				crc_d = crc_next;
			end else if (count_ext < plen_ext + SW'(4)) begin
				crc_d = crc_next;
			end else if (count_ext == plen_ext + SW'(4)) begin
				crc_field_d = {crc_field_q[15:8], b};
			end else if (count_ext == plen_ext + SW'(5)) begin
				crc_field_d = {b, crc_field_q[7:0]};
			end
		end

		if (clear) begin
			escape_d    = 1'b0;
			count_d     = '0;
			opcode_d    = '0;
			seq_d       = '0;
			length_d    = '0;
			crc_d       = sdc_pkg::CRC_INIT;
			crc_field_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_q    <= 1'b0;
			count_q     <= '0;
			opcode_q    <= '0;
			seq_q       <= '0;
			length_q    <= '0;
			crc_q       <= sdc_pkg::CRC_INIT;
			crc_field_q <= '0;
		end else if (step) begin
			escape_q    <= escape_d;
			count_q     <= count_d;
			opcode_q    <= opcode_d;
			seq_q       <= seq_d;
			length_q    <= length_d;
			crc_q       <= crc_d;
			crc_field_q <= crc_field_d;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/slip_deframer_crc16_check_unit.sv =====
// Top level of the SLIP deframer with CRC-16 check: input register, sdc_core, result register.
// Depends on sdc_pkg and sdc_core.
//
// Each received byte is taken into an input register and handled from there once the output
// register can take a result; the escape decoder, the frame counters and a byte-wide unrolled
// CRC update work in one pass and the result lands in an output register. One byte can be
// accepted in every cycle as long as results are taken, so the sustained rate is one item
// per cycle and is limited only by the single output register: while it holds an untaken
// result the input stalls.
// Bytes that yield no result (END of an empty frame, ESC, a bad escape pair) still pass
// through the output stage slot.
`default_nettype none

module slip_deframer_crc16_check_unit #(
	parameter int MAX_FRAME   = 256,
	parameter int MAX_PAYLOAD = 250
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,   // [7:0] data_byte, [15:8] frame_opcode, [23:16] frame_seq,
	                                    // [31:24] frame_plen, [47:32] received_crc,
	                                    // [63:48] computed_crc
	output logic [2:0]       m_tuser    // [2:0] kind
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             out_free;
	logic             advance;
	sdc_pkg::result_t result;
	logic             m_valid_q;
	logic [63:0]      m_data_q;
	logic [2:0]       m_kind_q;

	assign out_free = !m_valid_q || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	sdc_core #(
		.MAX_FRAME   (MAX_FRAME),
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= advance && result.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.valid && out_free) begin
			m_data_q <= {result.computed_crc, result.received_crc, result.frame_plen,
				result.frame_seq, result.frame_opcode, result.data_byte};
			m_kind_q <= result.kind;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_kind_q;

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser <= sdc_pkg::KIND_OVERFLOW))
		else $error("result kind out of range");

	a_status_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == sdc_pkg::KIND_RUNT || m_tuser == sdc_pkg::KIND_OVERFLOW))
		|-> (m_tdata == 64'd0))
		else $error("runt or overflow result carries data");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && m_tvalid && !m_tready) |-> !s_tready)
		else $error("input accepted while the pipeline is stalled");

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("input not ready with an empty input register");

endmodule

`default_nettype wire

// ===== test/tb_slip_deframer_crc16_check_unit.sv =====
// Testbench for slip_deframer_crc16_check_unit: a directed byte table, then random SLIP frames,
// each result checked against a predictor of the deframer and its CRC-16 check.
// Depends on sdc_pkg and the RTL of the unit; needs no files or arguments.
`timescale 1ns / 1ps

module tb_slip_deframer_crc16_check_unit;

	localparam int MAX_FRAME    = 256;
	localparam int MAX_PAYLOAD  = 250;
	localparam int RAND_ITEMS   = 825;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 250;
	localparam int LIMIT_CYCLES = 400000;

	typedef struct packed {
		sdc_pkg::kind_t kind;
		logic [7:0]     data;
		logic [7:0]     opcode;
		logic [7:0]     seq;
		logic [7:0]     plen;
		logic [15:0]    rx_crc;
		logic [15:0]    calc_crc;
	} slip_result_t;

	typedef enum logic [1:0] {
		ROW_RAW,
		ROW_CRC_LO,
		ROW_CRC_HI
	} row_op_t;

	typedef struct packed {
		row_op_t        op;
		logic [7:0]     b;
		logic           fixed;
		sdc_pkg::kind_t kind;
		logic [7:0]     data;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic [2:0]  m_tuser;

	logic           drv_fixed = 1'b0;
	sdc_pkg::kind_t drv_kind = sdc_pkg::KIND_DATA;
	logic [7:0]     drv_data = 8'h00;
	logic           calm = 1'b0;

	slip_result_t decoded_due[$];
	int mismatches = 0;
	int items_sent = 0;
	int items_taken = 0;
	int frames_sent = 0;
	int cycles = 0;
	int kind_seen[5] = '{0, 0, 0, 0, 0};

	// Deframer state as the predictor sees it.
	logic        fr_esc = 1'b0;
	int          fr_count = 0;
	logic [7:0]  fr_op = 8'h00;
	logic [7:0]  fr_seq = 8'h00;
	logic [15:0] fr_len = 16'h0000;
	logic [15:0] fr_crc = sdc_pkg::CRC_INIT;
	logic [15:0] fr_crc_rx = 16'h0000;

	dir_row_t dir_rows [25] = '{
		'{ROW_RAW, sdc_pkg::SLIP_END, 1'b0, sdc_pkg::KIND_DATA, 8'h00},
		'{ROW_RAW, 8'h00, 1'b1, sdc_pkg::KIND_DATA, 8'h00},
		'{ROW_RAW, sdc_pkg::SLIP_END, 1'b1, sdc_pkg::KIND_RUNT, 8'h00},
		'{ROW_RAW, 8'hFF, 1'b1, sdc_pkg::KIND_DATA, 8'hFF},
		'{ROW_RAW, sdc_pkg::SLIP_ESC, 1'b0, sdc_pkg::KIND_DATA, 8'h00},
		'{ROW_RAW, sdc_pkg::SLIP_ESC_END, 1'b1, sdc_pkg::KIND_DATA, sdc_pkg::SLIP_END},
		'{ROW_RAW, sdc_pkg::SLIP_ESC, 1'b0, sdc_pkg::KIND_DATA, 8'h00},
		'{ROW_RAW, sdc_pkg::SLIP_ESC_ESC, 1'b1, sdc_pkg::KIND_DATA, sdc_pkg::SLIP_ESC},
		'{ROW_RAW, sdc_pkg::SLIP_ESC, 1'b0, sdc_pkg::KIND_DATA, 8'h00},
		'{ROW_RAW, 8'h41, 1'b0, sdc_pkg::KIND_DATA, 8'h00},
		'{ROW_RAW, sdc_pkg::SLIP_ESC, 1'b0, sdc_pkg::KIND_DATA, 8'h00},
		'{ROW_RAW, sdc_pkg::SLIP_ESC, 1'b0, sdc_pkg::KIND_DATA, 8'h00},
		'{ROW_RAW, sdc_pkg::SLIP_ESC_END, 1'b1, sdc_pkg::KIND_DATA, sdc_pkg::SLIP_END},
		'{ROW_RAW, sdc_pkg::SLIP_ESC, 1'b0, sdc_pkg::KIND_DATA, 8'h00},
		'{ROW_RAW, sdc_pkg::SLIP_END, 1'b0, sdc_pkg::KIND_DATA, 8'h00},
		'{ROW_RAW, 8'h01, 1'b1, sdc_pkg::KIND_DATA, 8'h01},
		'{ROW_RAW, 8'h80, 1'b1, sdc_pkg::KIND_DATA, 8'h80},
		'{ROW_RAW, 8'h00, 1'b1, sdc_pkg::KIND_DATA, 8'h00},
		'{ROW_RAW, 8'h00, 1'b1, sdc_pkg::KIND_DATA, 8'h00},
		'{ROW_CRC_LO, 8'h00, 1'b0, sdc_pkg::KIND_DATA, 8'h00},
		'{ROW_CRC_HI, 8'h00, 1'b0, sdc_pkg::KIND_DATA, 8'h00},
		'{ROW_RAW, 8'h7E, 1'b1, sdc_pkg::KIND_DATA, 8'h7E},
		'{ROW_RAW, sdc_pkg::SLIP_END, 1'b0, sdc_pkg::KIND_DATA, 8'h00},
		'{ROW_RAW, 8'h55, 1'b1, sdc_pkg::KIND_DATA, 8'h55},
		'{ROW_RAW, sdc_pkg::SLIP_END, 1'b1, sdc_pkg::KIND_RUNT, 8'h00}
	};

	slip_deframer_crc16_check_unit #(
		.MAX_FRAME(MAX_FRAME),
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] c;
		c = acc ^ {b, 8'h00};
		repeat (8) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ sdc_pkg::CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 88) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	task automatic restart_frame();
		fr_esc = 1'b0;
		fr_count = 0;
		fr_op = 8'h00;
		fr_seq = 8'h00;
		fr_len = 16'h0000;
		fr_crc = sdc_pkg::CRC_INIT;
		fr_crc_rx = 16'h0000;
	endtask

	task automatic deframe_byte(input logic [7:0] raw, output logic has, output slip_result_t r);
		logic [7:0] b;
		logic keep;
		int plen;
		r = '0;
		has = 1'b0;
		b = raw;
		keep = 1'b1;
		plen = (fr_len > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(fr_len);
		if (fr_count >= MAX_FRAME) begin
			restart_frame();
			r.kind = sdc_pkg::KIND_OVERFLOW;
			has = 1'b1;
		end else if (raw == sdc_pkg::SLIP_END) begin
			if (fr_count > 0) begin
				has = 1'b1;
				if (fr_count < 4) begin
					r.kind = sdc_pkg::KIND_RUNT;
				end else begin
					r.kind = (fr_count >= 6 + plen && fr_crc_rx == fr_crc)
						? sdc_pkg::KIND_GOOD : sdc_pkg::KIND_MISMATCH;
					r.opcode = fr_op;
					r.seq = fr_seq;
					r.plen = plen[7:0];
					r.rx_crc = fr_crc_rx;
					r.calc_crc = fr_crc;
				end
			end
			restart_frame();
		end else if (raw == sdc_pkg::SLIP_ESC) begin
			fr_esc = 1'b1;
		end else begin
			if (fr_esc) begin
				fr_esc = 1'b0;
				if (raw == sdc_pkg::SLIP_ESC_END) begin
					b = sdc_pkg::SLIP_END;
				end else if (raw == sdc_pkg::SLIP_ESC_ESC) begin
					b = sdc_pkg::SLIP_ESC;
				end else begin
					keep = 1'b0;
				end
			end
			if (keep) begin
				case (fr_count)
					0: fr_op = b;
					1: fr_seq = b;
					2: fr_len[7:0] = b;
					3: fr_len[15:8] = b;
					default: ;
				endcase
				plen = (fr_len > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(fr_len);
				if (fr_count < 4 || fr_count < 4 + plen) begin
					fr_crc = crc_step(fr_crc, b);
				end else if (fr_count == 4 + plen) begin
					fr_crc_rx[7:0] = b;
				end else if (fr_count == 5 + plen) begin
					fr_crc_rx[15:8] = b;
				end
				fr_count++;
				has = 1'b1;
				r.kind = sdc_pkg::KIND_DATA;
				r.data = b;
			end
		end
	endtask

	task automatic flag_mismatch(input string what, input logic [15:0] got,
		input logic [15:0] want);
		if (mismatches < 40) begin
			$display("[%0t] %s: got %h, expected %h", $realtime, what, got, want);
		end
		mismatches++;
	endtask

	always @(posedge clk) begin : rx_side
		slip_result_t r;
		logic has;
		if (arst_n && s_tvalid && s_tready) begin
			deframe_byte(s_tdata, has, r);
			if (drv_fixed) begin
				r = '0;
				r.kind = drv_kind;
				r.data = drv_data;
				has = 1'b1;
			end
			if (has) begin
				decoded_due.push_back(r);
			end
			items_taken++;
		end
	end

	always @(posedge clk) begin : tx_side
		slip_result_t w;
		if (arst_n && m_tvalid && m_tready) begin
			if (decoded_due.size() == 0) begin
				flag_mismatch("result with none expected", {13'd0, m_tuser}, 16'h0000);
			end else begin
				w = decoded_due.pop_front();
				if (m_tuser !== w.kind) begin
					flag_mismatch("kind", {13'd0, m_tuser}, {13'd0, w.kind});
				end
				if (m_tdata[7:0] !== w.data) begin
					flag_mismatch("data_byte", {8'd0, m_tdata[7:0]}, {8'd0, w.data});
				end
				if (m_tdata[15:8] !== w.opcode) begin
					flag_mismatch("opcode", {8'd0, m_tdata[15:8]}, {8'd0, w.opcode});
				end
				if (m_tdata[23:16] !== w.seq) begin
					flag_mismatch("seq", {8'd0, m_tdata[23:16]}, {8'd0, w.seq});
				end
				if (m_tdata[31:24] !== w.plen) begin
					flag_mismatch("plen", {8'd0, m_tdata[31:24]}, {8'd0, w.plen});
				end
				if (m_tdata[47:32] !== w.rx_crc) begin
					flag_mismatch("received_crc", m_tdata[47:32], w.rx_crc);
				end
				if (m_tdata[63:48] !== w.calc_crc) begin
					flag_mismatch("computed_crc", m_tdata[63:48], w.calc_crc);
				end
				if (w.kind <= sdc_pkg::KIND_OVERFLOW) kind_seen[w.kind]++;
			end
		end
	end

	// The sink idles at random, and once holds off long enough to back up the input.
	initial begin : result_sink
		int n;
		logic held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && items_taken >= HOLD_AT) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
			n = calm ? 0 : idle_len();
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
	end

	task automatic offer(input logic [7:0] b, input logic fixed, input sdc_pkg::kind_t k,
		input logic [7:0] d);
		int gap;
		gap = calm ? 0 : idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		drv_fixed <= fixed;
		drv_kind <= k;
		drv_data <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
	endtask

	task automatic offer_raw(input logic [7:0] b);
		offer(b, 1'b0, sdc_pkg::KIND_DATA, 8'h00);
	endtask

	task automatic send_plain(input logic [7:0] b);
		if (b == sdc_pkg::SLIP_END) begin
			offer_raw(sdc_pkg::SLIP_ESC);
			offer_raw(sdc_pkg::SLIP_ESC_END);
		end else if (b == sdc_pkg::SLIP_ESC) begin
			offer_raw(sdc_pkg::SLIP_ESC);
			offer_raw(sdc_pkg::SLIP_ESC_ESC);
		end else begin
			offer_raw(b);
		end
	endtask

	task automatic pause_until_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (decoded_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [7:0] noisy_byte();
		case ($urandom_range(0, 5))
			0: return sdc_pkg::SLIP_END;
			1: return sdc_pkg::SLIP_ESC;
			2: return sdc_pkg::SLIP_ESC_END;
			3: return sdc_pkg::SLIP_ESC_ESC;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_frame(input int idx);
		logic [7:0] body[$];
		logic [15:0] lenf;
		logic [15:0] crc;
		logic [7:0] junk;
		int shape;
		int plen;
		shape = $urandom_range(0, 99);
		calm = ($urandom_range(0, 3) == 0);
		frames_sent++;
		if (shape < 10) begin
			repeat ($urandom_range(1, 6)) offer_raw(noisy_byte());
		end else if (shape < 16) begin
			repeat ($urandom_range(1, 3)) send_plain(8'($urandom_range(0, 255)));
			offer_raw(sdc_pkg::SLIP_END);
		end else begin
			if (idx == 6 || $urandom_range(0, 79) == 0) begin
				if ($urandom_range(0, 1) == 0) begin
					plen = $urandom_range(MAX_PAYLOAD - 2, MAX_PAYLOAD - 1);
					lenf = 16'(plen);
				end else begin
					plen = MAX_PAYLOAD;
					lenf = 16'($urandom_range(MAX_PAYLOAD, 65535));
				end
			end else begin
				plen = $urandom_range(0, 10);
				lenf = 16'(plen);
			end
			body.push_back(8'($urandom_range(0, 255)));
			body.push_back(8'($urandom_range(0, 255)));
			body.push_back(lenf[7:0]);
			body.push_back(lenf[15:8]);
			repeat (plen) body.push_back(8'($urandom_range(0, 255)));
			crc = sdc_pkg::CRC_INIT;
			foreach (body[i]) crc = crc_step(crc, body[i]);
			if ($urandom_range(0, 9) == 0) crc ^= 16'(1 << $urandom_range(0, 15));
			body.push_back(crc[7:0]);
			body.push_back(crc[15:8]);
			if (shape < 24) begin
				repeat ($urandom_range(1, 4)) body.push_back(8'($urandom_range(0, 255)));
			end else if (shape < 34) begin
				repeat ($urandom_range(1, body.size() - 4)) void'(body.pop_back());
			end
			foreach (body[i]) begin
				if ($urandom_range(0, 49) == 0) begin
					do junk = 8'($urandom_range(0, 255));
					while (junk == sdc_pkg::SLIP_END || junk == sdc_pkg::SLIP_ESC
						|| junk == sdc_pkg::SLIP_ESC_END || junk == sdc_pkg::SLIP_ESC_ESC);
					offer_raw(sdc_pkg::SLIP_ESC);
					offer_raw(junk);
				end
				send_plain(body[i]);
			end
			if ($urandom_range(0, 19) == 0) offer_raw(sdc_pkg::SLIP_ESC);
			offer_raw(sdc_pkg::SLIP_END);
		end
	endtask

	initial begin : stimulus
		dir_row_t row;
		logic [15:0] tab_crc;
		logic mid_done;
		int frame_no;
		int w;
		tab_crc = sdc_pkg::CRC_INIT;
		mid_done = 1'b0;
		frame_no = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			case (row.op)
				ROW_CRC_LO: send_plain(tab_crc[7:0]);
				ROW_CRC_HI: send_plain(tab_crc[15:8]);
				default: begin
					offer(row.b, row.fixed, row.kind, row.data);
					tab_crc = (row.b == sdc_pkg::SLIP_END) ? sdc_pkg::CRC_INIT
						: crc_step(tab_crc, row.b);
				end
			endcase
		end
		calm = 1'b0;
		pause_until_drained();

		while (items_sent < $size(dir_rows) + RAND_ITEMS) begin
			if (!mid_done && items_sent >= $size(dir_rows) + RAND_ITEMS / 2) begin
				mid_done = 1'b1;
				pause_until_drained();
			end
			send_frame(frame_no);
			frame_no++;
		end
		s_tvalid <= 1'b0;
		calm = 1'b0;

		w = 0;
		while (decoded_due.size() != 0 && w < 5000) begin
			@(posedge clk);
			w++;
		end
		repeat (16) @(posedge clk);
		if (decoded_due.size() != 0) begin
			flag_mismatch("results never delivered", 16'(decoded_due.size()), 16'h0000);
		end

		$display("Sent %0d bytes: %0d directed, then %0d random frames and noise runs.",
			items_sent, $size(dir_rows), frames_sent);
		$display("Checked %0d data, %0d good, %0d crc mismatch, %0d runt, %0d overflow.",
			kind_seen[sdc_pkg::KIND_DATA], kind_seen[sdc_pkg::KIND_GOOD],
			kind_seen[sdc_pkg::KIND_MISMATCH], kind_seen[sdc_pkg::KIND_RUNT],
			kind_seen[sdc_pkg::KIND_OVERFLOW]);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
